/* hw/rtl/lbqs_pkg.sv */
package lbqs_pkg;

    localparam int MAX_BUCKETS_DEF   = 128;
    localparam int LOG_FRAC_BITS_DEF = 16;

    localparam logic [7:0]  MAX_BUCKETS_RST   = 8'd100;
    localparam logic [31:0] INV_LOG2_BASE_RST = 32'd226370;

    localparam logic CFG_MAX_BUCKETS   = 1'b0;
    localparam logic CFG_INV_LOG2_BASE = 1'b1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [1:0] OUT_HIT     = 2'd0;
    localparam logic [1:0] OUT_NEW     = 2'd1;
    localparam logic [1:0] OUT_REPLACE = 2'd2;
    localparam logic [1:0] OUT_CLEARED = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic norm_step;  // one step of the leading-one search
        logic sq_step;    // one squaring step of the log
        logic mul_lo;     // low half product of log times reciprocal
        logic mul_hi;     // high half product and key rounding
        logic scan_start; // reset the scan pointer
        logic rd_issue;   // read the entry at the scan pointer
        logic find_eval;  // compare the read key, advance
        logic min_eval;   // compare the read count, advance
        logic sh_rd;      // read the entry behind the gap
        logic sh_wr;      // write it into the gap, advance
        logic do_hit;     // increment the found bucket
        logic do_append;  // append a new bucket
        logic do_replace; // write the new bucket at the tail
        logic do_clear;   // empty the store
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic zero_value;
        logic norm_done;
        logic found;
        logic scan_end;   // pointer reached the occupancy
        logic store_full;
        logic shift_end;  // gap reached the tail
    } t_stat;

endpackage

/* hw/rtl/lbqs_ctrl.sv */
module lbqs_ctrl #(
    parameter int LOG_FRAC_BITS = lbqs_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  lbqs_pkg::t_stat i_stat,
    output lbqs_pkg::t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_NORM   = 13'b0000000000010,
        S_SQ     = 13'b0000000000100,
        S_MULLO  = 13'b0000000001000,
        S_MULHI  = 13'b0000000010000,
        S_FRD    = 13'b0000000100000,
        S_FEV    = 13'b0000001000000,
        S_DECIDE = 13'b0000010000000,
        S_MRD    = 13'b0000100000000,
        S_MEV    = 13'b0001000000000,
        S_SHRD   = 13'b0010000000000,
        S_SHWR   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    localparam int CW = $clog2(LOG_FRAC_BITS + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_NORM;
                end
            end
            S_NORM: begin
                if (i_stat.is_clear) begin
                    o_cmd.do_clear = 1'b1;
                    n_state        = S_OUT;
                end else if (i_stat.zero_value) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_FRD;
                end else if (i_stat.norm_done) begin
                    n_cnt   = '0;
                    n_state = S_SQ;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CW'(LOG_FRAC_BITS - 1)) begin
                    n_state = S_MULLO;
                end
            end
            S_MULLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MULHI;
            end
            S_MULHI: begin
                o_cmd.mul_hi     = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = S_FRD;
            end
            S_FRD: begin
                if (i_stat.scan_end) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_FEV;
                end
            end
            S_FEV: begin
                o_cmd.find_eval = 1'b1;
                n_state         = S_FRD;
                if (i_stat.found) begin
                    o_cmd.do_hit = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_DECIDE: begin
                if (!i_stat.store_full) begin
                    o_cmd.do_append = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_MRD;
                end
            end
            S_MRD: begin
                if (i_stat.scan_end) begin
                    n_state = S_SHRD;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_MEV;
                end
            end
            S_MEV: begin
                o_cmd.min_eval = 1'b1;
                n_state        = S_MRD;
            end
            S_SHRD: begin
                if (i_stat.shift_end) begin
                    o_cmd.do_replace = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = S_SHRD;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lbqs_dp.sv */
module lbqs_dp #(
    parameter int MAX_BUCKETS   = lbqs_pkg::MAX_BUCKETS_DEF,
    parameter int LOG_FRAC_BITS = lbqs_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lbqs_pkg::t_cmd  i_cmd,
    output lbqs_pkg::t_stat o_stat,
    input  logic            i_opcode,
    input  logic [30:0]     i_sample_value,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output logic [15:0]     o_bucket_index,
    output logic [1:0]      o_outcome,
    output logic [31:0]     o_bucket_tally,
    output logic [31:0]     o_total_tally,
    output logic [7:0]      o_occupancy
);

    localparam int AW  = $clog2(MAX_BUCKETS);
    localparam int UW  = $clog2(MAX_BUCKETS + 1);
    localparam int LW  = 5 + LOG_FRAC_BITS;       // log2 width
    localparam int SH  = LOG_FRAC_BITS + 16;
    localparam int LLO = LW / 2;
    localparam int LHI = LW - LLO;

    // Configuration registers.
    logic [7:0]  r_max_buckets;
    logic [31:0] r_inv_log2_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_buckets   <= lbqs_pkg::MAX_BUCKETS_RST;
            r_inv_log2_base <= lbqs_pkg::INV_LOG2_BASE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == lbqs_pkg::CFG_MAX_BUCKETS) begin
                r_max_buckets <= i_cfg_data[7:0];
            end else begin
                r_inv_log2_base <= i_cfg_data;
            end
        end
    end

    // Bucket store.
    logic [15:0] mem_key [MAX_BUCKETS];
    logic [31:0] mem_cnt [MAX_BUCKETS];
    logic [15:0] r_rd_key;
    logic [31:0] r_rd_cnt;

    logic          r_op;
    logic [30:0]   r_val;
    logic [4:0]    r_n;
    logic [31:0]   r_m;
    logic [LOG_FRAC_BITS-1:0] r_frac;
    logic [LLO+31:0] r_plo;
    logic [15:0]   r_key;
    logic [UW-1:0] r_ptr;
    logic [UW-1:0] r_used;
    logic [31:0]   r_total;
    logic [31:0]   r_small_cnt;
    logic [UW-1:0] r_gap;

    // One squaring step of the log.
    logic [63:0] sq_prod;
    logic [33:0] sq_m;
    assign sq_prod = r_m * r_m;
    assign sq_m    = sq_prod[63:30];

    // Log times reciprocal, split in two halves of the log.
    logic [LW-1:0]     log_fix;
    logic [LHI+31:0]   p_hi;
    logic [LW+31:0]    prod;
    logic [LW+31:0]    prod_rnd;
    logic [LW+31-SH:0] q;
    assign log_fix  = {r_n, r_frac};
    assign p_hi     = log_fix[LW-1:LLO] * r_inv_log2_base;
    assign prod     = {p_hi, {LLO{1'b0}}} + (LW+32)'(r_plo);
    assign prod_rnd = prod + (LW+32)'({SH{1'b1}});
    assign q        = prod_rnd[LW+31:SH];

    logic [UW-1:0] limit;
    assign limit = (32'(r_max_buckets) > 32'(MAX_BUCKETS)) ? UW'(MAX_BUCKETS)
                                                            : UW'(r_max_buckets);

    logic [AW-1:0] ptr_a, used_a, gap_a, gap1_a;
    assign ptr_a  = r_ptr[AW-1:0];
    assign used_a = AW'(r_used - 1'b1);
    assign gap_a  = r_gap[AW-1:0];
    assign gap1_a = AW'(r_gap + 1'b1);

    always_comb begin
        o_stat            = '0;
        o_stat.is_clear   = (r_op == lbqs_pkg::OP_CLEAR);
        o_stat.zero_value = (r_val == '0);
        o_stat.norm_done  = r_m[30];
        o_stat.found      = (r_rd_key == r_key);
        o_stat.scan_end   = (r_ptr == r_used);
        o_stat.store_full = (r_used != '0) && (r_used >= limit);
        o_stat.shift_end  = ((r_gap + 1'b1) == r_used);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_key <= mem_key[ptr_a];
            r_rd_cnt <= mem_cnt[ptr_a];
        end else if (i_cmd.sh_rd) begin
            r_rd_key <= mem_key[gap1_a];
            r_rd_cnt <= mem_cnt[gap1_a];
        end
        if (i_cmd.sh_wr) begin
            mem_key[gap_a] <= r_rd_key;
            mem_cnt[gap_a] <= r_rd_cnt;
        end else if (i_cmd.do_hit) begin
            mem_cnt[ptr_a] <= r_rd_cnt + 32'd1;
        end else if (i_cmd.do_append) begin
            mem_key[r_used[AW-1:0]] <= r_key;
            mem_cnt[r_used[AW-1:0]] <= 32'd1;
        end else if (i_cmd.do_replace) begin
            mem_key[used_a] <= r_key;
            mem_cnt[used_a] <= r_small_cnt + 32'd1;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_val  <= i_sample_value;
            r_n    <= 5'd30;
            r_m    <= {1'b0, i_sample_value};
            r_frac <= '0;
            r_key  <= 16'hFFFF;
        end
        if (i_cmd.norm_step) begin
            r_m <= {r_m[30:0], 1'b0};
            r_n <= r_n - 5'd1;
        end
        if (i_cmd.sq_step) begin
            if (sq_m[31]) begin
                r_m    <= sq_m[32:1];
                r_frac <= {r_frac[LOG_FRAC_BITS-2:0], 1'b1};
            end else begin
                r_m    <= sq_m[31:0];
                r_frac <= {r_frac[LOG_FRAC_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.mul_lo) begin
            r_plo <= log_fix[LLO-1:0] * r_inv_log2_base;
        end
        if (i_cmd.mul_hi) begin
            r_key <= (q > (LW+32-SH)'(32767)) ? 16'd32767 : 16'(q);
        end
        if (i_cmd.scan_start) begin
            r_ptr       <= '0;
            r_small_cnt <= '0;
        end
        if (i_cmd.find_eval) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.min_eval) begin
            if (r_ptr == '0 || r_rd_cnt < r_small_cnt) begin
                r_small_cnt <= r_rd_cnt;
            end
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.min_eval && r_ptr == '0) begin
            r_gap <= '0;
        end else if (i_cmd.min_eval && r_rd_cnt < r_small_cnt) begin
            r_gap <= UW'(r_ptr);
        end else if (i_cmd.sh_wr) begin
            r_gap <= r_gap + 1'b1;
        end
        if (i_cmd.do_hit) begin
            o_bucket_tally <= r_rd_cnt + 32'd1;
            o_outcome      <= lbqs_pkg::OUT_HIT;
        end
        if (i_cmd.do_append) begin
            o_bucket_tally <= 32'd1;
            o_outcome      <= lbqs_pkg::OUT_NEW;
        end
        if (i_cmd.do_replace) begin
            o_bucket_tally <= r_small_cnt + 32'd1;
            o_outcome      <= lbqs_pkg::OUT_REPLACE;
        end
        if (i_cmd.do_clear) begin
            o_bucket_tally <= '0;
            o_outcome      <= lbqs_pkg::OUT_CLEARED;
        end
    end

    // Control state of the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_total <= '0;
        end else if (i_cmd.do_clear) begin
            r_used  <= '0;
            r_total <= '0;
        end else if (i_cmd.do_hit || i_cmd.do_replace) begin
            r_total <= r_total + 32'd1;
        end else if (i_cmd.do_append) begin
            r_used  <= r_used + 1'b1;
            r_total <= r_total + 32'd1;
        end
    end

    assign o_bucket_index = (r_op == lbqs_pkg::OP_CLEAR) ? 16'd0 : r_key;
    assign o_total_tally  = r_total;
    assign o_occupancy    = 8'(r_used);

endmodule

/* hw/rtl/log_bucket_quantile_sketch.sv */
// The log is a leading-one search, 16 squarings and two half products; then comes the key
// search over the stored buckets and, on a full store, a minimum scan over the buckets and
// the close-up of the entries behind the gap.
// Throughput: one item at a time; the next transfer is taken after the result is taken.
// Reset (synchronous, active low) empties the store and loads the register defaults; the
// bucket memory itself is not cleared.
module log_bucket_quantile_sketch #(
    parameter int MAX_BUCKETS   = lbqs_pkg::MAX_BUCKETS_DEF,
    parameter int LOG_FRAC_BITS = lbqs_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // sample_value[30:0]
    input  logic         s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // bucket_index, bucket_tally, total_tally, occupancy
    output logic [1:0]   m_axis_tuser,  // outcome
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    lbqs_pkg::t_cmd  cmd;
    lbqs_pkg::t_stat stat;
    logic [15:0] bucket_index;
    logic [31:0] bucket_tally, total_tally;
    logic [7:0]  occupancy;

    // The controller sequences the log, the search, the minimum scan and the close-up.
    lbqs_ctrl #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lbqs_dp #(.MAX_BUCKETS(MAX_BUCKETS), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (s_axis_tuser),
        .i_sample_value (s_axis_tdata[30:0]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_bucket_index (bucket_index),
        .o_outcome      (m_axis_tuser),
        .o_bucket_tally (bucket_tally),
        .o_total_tally  (total_tally),
        .o_occupancy    (occupancy)
    );

    // Fields packed from the lowest bit up; the top bits are zero padding.
    assign m_axis_tdata = {8'd0, occupancy, total_tally, bucket_tally, bucket_index};

endmodule
